// ===== rtl/core/utf8_decode_classify_macros.svh =====
// Assertion macros shared by the UTF-8 decoder RTL files.
`ifndef UTF8_DECODE_CLASSIFY_MACROS_SVH
`define UTF8_DECODE_CLASSIFY_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked on every rising edge outside reset.
`define U8DC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define U8DC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`else

`define U8DC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define U8DC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== rtl/core/utf8dc_pkg.sv =====
// Types and constants shared by the UTF-8 decoder and classifier.
`default_nettype none

package utf8dc_pkg;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_BAD_LEAD  = 2'd1;
	localparam logic [1:0] ST_BAD_CONT  = 2'd2;
	localparam logic [1:0] ST_TRUNC     = 2'd3;

	localparam logic [15:0] CNT_MAX     = 16'hFFFF;
	localparam logic [20:0] CP_NEWLINE  = 21'h00000A;
	localparam logic [20:0] CP_UNDERSCORE = 21'h00005F;
	localparam logic [20:0] CJK_EXT_LO  = 21'h003400;
	localparam logic [20:0] CJK_EXT_HI  = 21'h004DBF;
	localparam logic [20:0] CJK_MAIN_LO = 21'h004E00;
	localparam logic [20:0] CJK_MAIN_HI = 21'h009FFF;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       final_byte;
	} in_item_t;

	typedef struct packed {
		logic [20:0] code_point;
		logic [1:0]  status;
		logic        ident_start_ok;
		logic        ident_part_ok;
		logic [15:0] line_number;
		logic [15:0] column_number;
	} out_item_t;

	typedef struct packed {
		logic start_ok;
		logic part_ok;
	} ident_flags_t;

endpackage

`default_nettype wire

// ===== rtl/core/utf8_decode_classify.sv =====
// Top level of the UTF-8 decoder with identifier classification.
//
//   channel  direction  payload     handshake
//   text     in         in_item_t   text_valid / text_stall
//   char     out        out_item_t  char_valid / char_stall
//
// One byte is taken per cycle while text_stall is low; a byte is captured in the input register
// and then decoded into the result register, from which its result is offered on the char channel.
// The decode of a byte depends on the sequence state left by the previous byte,
// which is updated as that byte retires, so bytes follow back to back.
// Reset gives an idle decoder at line 1, column 1; no clearing pass is needed.
// A stalled result register holds back only a byte that produces a result.
`default_nettype none
`include "utf8_decode_classify_macros.svh"

module utf8_decode_classify (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  text_valid,
	output logic                       text_stall,
	input  wire utf8dc_pkg::in_item_t  text_data,
	output logic                       char_valid,
	input  wire logic                  char_stall,
	output utf8dc_pkg::out_item_t      char_data
);
	import utf8dc_pkg::*;

	in_item_t  item_s1;
	logic      valid_s1;
	logic      go_s1;
	logic      has_result;
	logic      out_blocked;
	logic      text_take;
	out_item_t result;

	utf8dc_decode u_decode (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (go_s1),
		.item       (item_s1),
		.has_result (has_result),
		.result     (result)
	);

	utf8dc_out_reg u_out_reg (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (go_s1 && has_result),
		.load_item    (result),
		.stall        (char_stall),
		.valid        (char_valid),
		.data         (char_data),
		.full_stalled (out_blocked)
	);

	// A byte without a result retires even while the result register is stalled.
	assign go_s1      = valid_s1 && (!has_result || !out_blocked);
	assign text_stall = valid_s1 && !go_s1;
	assign text_take  = text_valid && !text_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text_take) begin
			valid_s1 <= 1'b1;
		end else if (go_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (text_take) begin
			item_s1 <= text_data;
		end
	end

	`U8DC_ASSERT_NOW(a_no_overwrite, clk, arst_n,
		go_s1 && out_blocked, !has_result,
		"result loaded over a stalled result")

	`U8DC_ASSERT_NOW(a_error_is_blank, clk, arst_n,
		char_valid && (char_data.status != ST_OK),
		(char_data.code_point == 21'd0) && !char_data.ident_start_ok &&
		!char_data.ident_part_ok,
		"error result carries a code point or flags")

	`U8DC_ASSERT_NEXT(a_stall_holds_byte, clk, arst_n,
		text_stall, valid_s1 && $stable(item_s1),
		"input register changed while the text channel stalled")

endmodule

`default_nettype wire

// ===== rtl/core/utf8dc_classify.sv =====
// Identifier-start and identifier-part classification of a code point.
`default_nettype none

module utf8dc_classify (
	input  wire logic [20:0]               code_point,
	input  wire logic                      good,
	output utf8dc_pkg::ident_flags_t       flags
);
	import utf8dc_pkg::*;

	logic is_letter;
	logic is_numeral;
	logic is_under;
	logic in_main;
	logic in_ext;

	always_comb begin
		is_letter = ((code_point >= 21'h61) && (code_point <= 21'h7A)) ||
		            ((code_point >= 21'h41) && (code_point <= 21'h5A));
		is_numeral = (code_point >= 21'h30) && (code_point <= 21'h39);
		is_under  = (code_point == CP_UNDERSCORE);
		in_main   = (code_point >= CJK_MAIN_LO) && (code_point <= CJK_MAIN_HI);
		in_ext    = (code_point >= CJK_EXT_LO) && (code_point <= CJK_EXT_HI);

		flags.start_ok = good && (is_letter || is_under || (code_point >= CJK_MAIN_LO));
		flags.part_ok  = good && (is_letter || is_numeral || is_under || in_main || in_ext);
	end

endmodule

`default_nettype wire

// ===== rtl/core/utf8dc_decode.sv =====
// Sequence state, byte decode and line/column counters.
`default_nettype none
`include "utf8_decode_classify_macros.svh"

module utf8dc_decode (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 step,
	input  wire utf8dc_pkg::in_item_t item,
	output logic                      has_result,
	output utf8dc_pkg::out_item_t     result
);
	import utf8dc_pkg::*;

	logic [1:0]  pending_q;
	logic [20:0] partial_q;
	logic [15:0] line_q;
	logic [15:0] column_q;

	logic [1:0]   pending_d;
	logic [20:0]  partial_d;
	logic [15:0]  line_d;
	logic [15:0]  column_d;
	logic [20:0]  cp;
	logic [1:0]   status;
	logic         emit_char;
	logic         good;
	logic [20:0]  merged;
	logic [1:0]   pending_dec;
	logic [7:0]   b;
	ident_flags_t flags;

	utf8dc_classify u_classify (
		.code_point (cp),
		.good       (good),
		.flags      (flags)
	);

	always_comb begin
		b           = item.text_byte;
		merged      = {partial_q[14:0], b[5:0]};
		pending_dec = pending_q - 2'd1;
		pending_d   = pending_q;
		partial_d   = partial_q;
		has_result  = 1'b0;
		emit_char   = 1'b0;
		cp          = '0;
		status      = ST_OK;

		if (pending_q == 2'd0) begin
			if (!b[7]) begin
				has_result = 1'b1;
				emit_char  = 1'b1;
				cp         = {13'd0, b};
			end else if (b[7:6] == 2'b10) begin
				has_result = 1'b1;
				status     = ST_BAD_LEAD;
			end else if (b[7:5] == 3'b110) begin
				pending_d = 2'd1;
				partial_d = {16'd0, b[4:0]};
			end else if (b[7:4] == 4'b1110) begin
				pending_d = 2'd2;
				partial_d = {17'd0, b[3:0]};
			end else if (b[7:3] == 5'b11110) begin
				pending_d = 2'd3;
				partial_d = {18'd0, b[2:0]};
			end else begin
				has_result = 1'b1;
				status     = ST_BAD_LEAD;
			end
			// A lead byte that is also the last byte cannot complete.
			if (!has_result && item.final_byte) begin
				has_result = 1'b1;
				status     = ST_TRUNC;
			end
		end else begin
			if (b[7:6] != 2'b10) begin
				has_result = 1'b1;
				status     = ST_BAD_CONT;
			end else if (pending_dec == 2'd0) begin
				has_result = 1'b1;
				emit_char  = 1'b1;
				cp         = merged;
			end else begin
				pending_d = pending_dec;
				partial_d = merged;
				if (item.final_byte) begin
					has_result = 1'b1;
					status     = ST_TRUNC;
				end
			end
		end

		// Any result closes the open sequence.
		if (has_result) begin
			pending_d = 2'd0;
			partial_d = '0;
		end

		good     = (status == ST_OK);
		line_d   = line_q;
		column_d = column_q;
		if (emit_char) begin
			if (cp == CP_NEWLINE) begin
				if (line_q != CNT_MAX) begin
					line_d = line_q + 16'd1;
				end
				column_d = 16'd1;
			end else if (column_q != CNT_MAX) begin
				column_d = column_q + 16'd1;
			end
		end

		result.code_point     = cp;
		result.status         = status;
		result.ident_start_ok = flags.start_ok;
		result.ident_part_ok  = flags.part_ok;
		result.line_number    = line_q;
		result.column_number  = column_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 2'd0;
			partial_q <= '0;
			line_q    <= 16'd1;
			column_q  <= 16'd1;
		end else if (step) begin
			pending_q <= pending_d;
			partial_q <= partial_d;
			line_q    <= line_d;
			column_q  <= column_d;
		end
	end

	`U8DC_ASSERT_NEXT(a_error_closes_sequence, clk, arst_n,
		step && has_result && (status != ST_OK), pending_q == 2'd0,
		"error result left a sequence open")

	`U8DC_ASSERT_NOW(a_counters_nonzero, clk, arst_n,
		1'b1, (line_q != 16'd0) && (column_q != 16'd0),
		"line or column counter reached zero")

endmodule

`default_nettype wire

// ===== rtl/core/utf8dc_out_reg.sv =====
// Result register towards the character channel.
`default_nettype none

module utf8dc_out_reg (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  load,
	input  wire utf8dc_pkg::out_item_t load_item,
	input  wire logic                  stall,
	output logic                       valid,
	output utf8dc_pkg::out_item_t      data,
	output logic                       full_stalled
);
	import utf8dc_pkg::*;

	out_item_t data_q;
	logic      valid_q;

	// The register can take a new result when empty or when its transfer completes.
	assign full_stalled = valid_q && stall;
	assign valid        = valid_q;
	assign data         = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= load_item;
		end
	end

endmodule

`default_nettype wire

// ===== tb/utf8_decode_classify_checker.sv =====
// Checker for the UTF-8 decoder: predicts every decoded character and compares it with the output.
`timescale 1ns / 100ps

module utf8_decode_classify_checker (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  text_valid,
	input  logic                  text_stall,
	input  utf8dc_pkg::in_item_t  text_data,
	input  logic                  char_valid,
	input  logic                  char_stall,
	input  utf8dc_pkg::out_item_t char_data,
	output int                    mismatch_count,
	output int                    waiting_count,
	output int                    checked_count,
	output int                    error_result_count
);
	import utf8dc_pkg::*;

	localparam logic [20:0] CP_UPPER_A = 21'h41;
	localparam logic [20:0] CP_UPPER_Z = 21'h5A;
	localparam logic [20:0] CP_LOWER_A = 21'h61;
	localparam logic [20:0] CP_LOWER_Z = 21'h7A;
	localparam logic [20:0] CP_DIGIT_0 = 21'h30;
	localparam logic [20:0] CP_DIGIT_9 = 21'h39;

	logic [1:0]  cont_left;
	logic [20:0] cp_acc;
	logic [15:0] cur_line;
	logic [15:0] cur_col;
	out_item_t   char_expected_q[$];

	function automatic ident_flags_t classify_ident(input logic [20:0] cp);
		ident_flags_t f;
		logic letter;
		letter = (cp >= CP_UPPER_A && cp <= CP_UPPER_Z) || (cp >= CP_LOWER_A && cp <= CP_LOWER_Z);
		f.start_ok = letter || cp == CP_UNDERSCORE || cp >= CJK_MAIN_LO;
		f.part_ok = letter || (cp >= CP_DIGIT_0 && cp <= CP_DIGIT_9) || cp == CP_UNDERSCORE
			|| (cp >= CJK_MAIN_LO && cp <= CJK_MAIN_HI) || (cp >= CJK_EXT_LO && cp <= CJK_EXT_HI);
		return f;
	endfunction

	task automatic push_result(input logic [20:0] cp, input logic [1:0] st);
		out_item_t r;
		ident_flags_t f;
		f = classify_ident(cp);
		r.code_point = (st == ST_OK) ? cp : 21'd0;
		r.status = st;
		r.ident_start_ok = (st == ST_OK) && f.start_ok;
		r.ident_part_ok = (st == ST_OK) && f.part_ok;
		r.line_number = cur_line;
		r.column_number = cur_col;
		char_expected_q = {char_expected_q, r};
		cont_left = 2'd0;
		cp_acc = 21'd0;
	endtask

	task automatic push_char(input logic [20:0] cp);
		push_result(cp, ST_OK);
		if (cp == CP_NEWLINE) begin
			if (cur_line != CNT_MAX)
				cur_line = cur_line + 16'd1;
			cur_col = 16'd1;
		end else if (cur_col != CNT_MAX) begin
			cur_col = cur_col + 16'd1;
		end
	endtask

	task automatic decode_byte(input in_item_t it);
		logic [7:0] b;
		b = it.text_byte;
		if (cont_left == 2'd0) begin
			if (!b[7]) begin
				push_char({13'd0, b});
			end else if (b[7:6] == 2'b10) begin
				push_result(21'd0, ST_BAD_LEAD);
			end else if (b[7:5] == 3'b110) begin
				cont_left = 2'd1;
				cp_acc = {16'd0, b[4:0]};
			end else if (b[7:4] == 4'b1110) begin
				cont_left = 2'd2;
				cp_acc = {17'd0, b[3:0]};
			end else if (b[7:3] == 5'b11110) begin
				cont_left = 2'd3;
				cp_acc = {18'd0, b[2:0]};
			end else begin
				push_result(21'd0, ST_BAD_LEAD);
			end
		end else if (b[7:6] != 2'b10) begin
			// The offending byte is dropped even if it could open a sequence.
			push_result(21'd0, ST_BAD_CONT);
		end else begin
			cp_acc = {cp_acc[14:0], b[5:0]};
			cont_left = cont_left - 2'd1;
			if (cont_left == 2'd0)
				push_char(cp_acc);
		end
		if (cont_left != 2'd0 && it.final_byte)
			push_result(21'd0, ST_TRUNC);
	endtask

	task automatic report(input string what, input out_item_t want, input out_item_t got);
		mismatch_count++;
		if (mismatch_count <= 10) begin
			$display("%0t %s: expected cp=%h st=%0d start=%0b part=%0b line=%0d col=%0d",
				$time, what, want.code_point, want.status, want.ident_start_ok,
				want.ident_part_ok, want.line_number, want.column_number);
			$display("    actual cp=%h st=%0d start=%0b part=%0b line=%0d col=%0d",
				got.code_point, got.status, got.ident_start_ok, got.ident_part_ok,
				got.line_number, got.column_number);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cont_left = 2'd0;
			cp_acc = 21'd0;
			cur_line = 16'd1;
			cur_col = 16'd1;
			char_expected_q.delete();
			mismatch_count = 0;
			checked_count = 0;
			error_result_count = 0;
		end else begin
			if (char_valid && !char_stall) begin
				if (char_expected_q.size() == 0) begin
					report("unexpected character", '0, char_data);
				end else begin
					out_item_t want;
					want = char_expected_q.pop_front();
					checked_count++;
					if (want.status != ST_OK)
						error_result_count++;
					if (char_data.code_point !== want.code_point
						|| char_data.status !== want.status
						|| char_data.ident_start_ok !== want.ident_start_ok
						|| char_data.ident_part_ok !== want.ident_part_ok
						|| char_data.line_number !== want.line_number
						|| char_data.column_number !== want.column_number)
						report("character mismatch", want, char_data);
				end
			end
			if (text_valid && !text_stall)
				decode_byte(text_data);
		end
		waiting_count = char_expected_q.size();
	end

endmodule

// ===== tb/tb_utf8_decode_classify.sv =====
// Testbench top for the UTF-8 decoder: clock, reset, byte stimulus, stalls and verdict.
`timescale 1ns / 100ps

module tb_utf8_decode_classify;
	import utf8dc_pkg::*;

	localparam int RANDOM_BYTES = 1060;
	localparam int FLAT_RUN = 30;

	logic      clk;
	logic      arst_n;
	logic      text_valid;
	logic      text_stall;
	in_item_t  text_data;
	logic      char_valid;
	logic      char_stall;
	out_item_t char_data;

	int mismatch_count;
	int waiting_count;
	int checked_count;
	int error_result_count;
	int bytes_sent;
	int text_count;
	bit sender_idles;
	bit receiver_idles;
	in_item_t text_buf[$];

	utf8_decode_classify dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.text_valid (text_valid),
		.text_stall (text_stall),
		.text_data  (text_data),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_data  (char_data)
	);

	utf8_decode_classify_checker u_checker (
		.clk                (clk),
		.arst_n             (arst_n),
		.text_valid         (text_valid),
		.text_stall         (text_stall),
		.text_data          (text_data),
		.char_valid         (char_valid),
		.char_stall         (char_stall),
		.char_data          (char_data),
		.mismatch_count     (mismatch_count),
		.waiting_count      (waiting_count),
		.checked_count      (checked_count),
		.error_result_count (error_result_count)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	initial begin
		#10_000_000;
		$display("[utf8_decode_classify] ERROR");
		$finish;
	end

	// Output stalls come in bursts; the payload is held by the block meanwhile.
	initial begin
		char_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (receiver_idles && $urandom_range(0, 7) == 0) begin
				char_stall = 1'b1;
				repeat ($urandom_range(1, 16)) @(negedge clk);
				char_stall = 1'b0;
			end
		end
	end

	// Called at a falling edge; returns at the falling edge after the transfer.
	task automatic send_byte(input in_item_t it);
		if (sender_idles && $urandom_range(0, 5) == 0) begin
			text_valid = 1'b0;
			text_data = in_item_t'($urandom);
			repeat ($urandom_range(1, 16)) @(negedge clk);
		end
		text_valid = 1'b1;
		text_data = it;
		@(posedge clk);
		while (text_stall)
			@(posedge clk);
		@(negedge clk);
		text_valid = 1'b0;
		bytes_sent++;
	endtask

	task automatic send_buffer();
		while (text_buf.size() != 0)
			send_byte(text_buf.pop_front());
	endtask

	task automatic wait_drained();
		text_valid = 1'b0;
		while (waiting_count != 0)
			@(negedge clk);
	endtask

	task automatic add_byte(input logic [7:0] b, input bit fin);
		in_item_t it;
		it.text_byte = b;
		it.final_byte = fin;
		text_buf = {text_buf, it};
	endtask

	// Encodes with the given length whatever the value, so short values give overlong forms.
	task automatic add_encoded(input logic [20:0] cp, input int nb);
		case (nb)
			1: add_byte({1'b0, cp[6:0]}, 1'b0);
			2: begin
				add_byte({3'b110, cp[10:6]}, 1'b0);
				add_byte({2'b10, cp[5:0]}, 1'b0);
			end
			3: begin
				add_byte({4'b1110, cp[15:12]}, 1'b0);
				add_byte({2'b10, cp[11:6]}, 1'b0);
				add_byte({2'b10, cp[5:0]}, 1'b0);
			end
			default: begin
				add_byte({5'b11110, cp[20:18]}, 1'b0);
				add_byte({2'b10, cp[17:12]}, 1'b0);
				add_byte({2'b10, cp[11:6]}, 1'b0);
				add_byte({2'b10, cp[5:0]}, 1'b0);
			end
		endcase
	endtask

	// Leaves a lead byte and possibly some continuations, never the whole sequence.
	task automatic add_cut_sequence();
		int nb;
		nb = $urandom_range(2, 4);
		add_encoded(21'($urandom), nb);
		repeat ($urandom_range(1, nb - 1))
			void'(text_buf.pop_back());
	endtask

	task automatic add_random_char();
		int pick;
		logic [20:0] cp;
		logic [7:0] bad;
		pick = $urandom_range(0, 99);
		if (pick < 35) begin
			case ($urandom_range(0, 5))
				0: cp = 21'(21'h41 + $urandom_range(0, 25));
				1: cp = 21'(21'h61 + $urandom_range(0, 25));
				2: cp = 21'(21'h30 + $urandom_range(0, 9));
				3: cp = CP_UNDERSCORE;
				4: cp = CP_NEWLINE;
				default: cp = 21'($urandom_range(0, 127));
			endcase
			add_encoded(cp, 1);
		end else if (pick < 50) begin
			add_encoded(21'($urandom_range(0, 21'h7FF)), 2);
		end else if (pick < 72) begin
			case ($urandom_range(0, 10))
				0: cp = 21'h33FF;
				1: cp = CJK_EXT_LO;
				2: cp = CJK_EXT_HI;
				3: cp = 21'h4DC0;
				4: cp = 21'h4DFF;
				5: cp = CJK_MAIN_LO;
				6: cp = CJK_MAIN_HI;
				7: cp = 21'hA000;
				8: cp = 21'($urandom_range(CJK_EXT_LO, CJK_EXT_HI));
				9: cp = 21'($urandom_range(CJK_MAIN_LO, CJK_MAIN_HI));
				default: cp = 21'($urandom_range(0, 16'hFFFF));
			endcase
			add_encoded(cp, 3);
		end else if (pick < 85) begin
			add_encoded(21'($urandom_range(0, 21'h1FFFFF)), 4);
		end else begin
			case ($urandom_range(0, 3))
				0: add_byte(8'($urandom), 1'b0);
				1: add_byte({2'b10, 6'($urandom)}, 1'b0);
				2: add_byte(8'($urandom_range(8'hF8, 8'hFF)), 1'b0);
				default: begin
					add_cut_sequence();
					bad = 8'($urandom);
					if (bad[7:6] == 2'b10)
						bad[6] = 1'b1;
					add_byte(bad, 1'b0);
				end
			endcase
		end
	endtask

	task automatic add_random_text();
		int n_chars;
		n_chars = $urandom_range(1, 10);
		if ($urandom_range(0, 19) == 0)
			n_chars = $urandom_range(20, 60);
		repeat (n_chars)
			add_random_char();
		if ($urandom_range(0, 4) == 0)
			add_cut_sequence();
		text_buf[text_buf.size() - 1].final_byte = 1'b1;
	endtask

	initial begin
		int random_start;
		arst_n = 1'b0;
		text_valid = 1'b0;
		text_data = '0;
		bytes_sent = 0;
		text_count = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Field extremes, each sequence length, the lower edges of both CJK ranges and every error kind.
		add_byte(8'h00, 1'b0);
		add_byte(8'h5F, 1'b0);
		add_byte(8'h0A, 1'b0);
		add_byte(8'h7F, 1'b0);
		add_byte(8'h80, 1'b0);
		add_byte(8'hFF, 1'b0);
		add_byte(8'hC2, 1'b0);
		add_byte(8'hA9, 1'b0);
		add_byte(8'hE4, 1'b0);
		add_byte(8'hB8, 1'b0);
		add_byte(8'h80, 1'b0);
		add_byte(8'hE3, 1'b0);
		add_byte(8'h90, 1'b0);
		add_byte(8'h80, 1'b0);
		add_byte(8'hF7, 1'b0);
		add_byte(8'hBF, 1'b0);
		add_byte(8'hBF, 1'b0);
		add_byte(8'hBF, 1'b1);
		add_byte(8'hC3, 1'b0);
		add_byte(8'h41, 1'b1);
		add_byte(8'hE2, 1'b0);
		add_byte(8'h82, 1'b1);
		add_byte(8'hF8, 1'b1);
		add_byte(8'hC0, 1'b1);
		send_buffer();
		wait_drained();

		random_start = bytes_sent;
		while (bytes_sent - random_start < RANDOM_BYTES) begin
			if (text_count % 15 == 0) begin
				sender_idles = $urandom_range(0, 2) != 0;
				receiver_idles = $urandom_range(0, 2) != 0;
			end
			add_random_text();
			send_buffer();
			if (text_count % 60 == 25)
				wait_drained();
			text_count++;
		end

		// Closing stretch runs flat out with plain letters, then newlines.
		sender_idles = 1'b0;
		receiver_idles = 1'b0;
		repeat (FLAT_RUN)
			send_byte({8'h78, 1'b0});
		repeat (FLAT_RUN)
			send_byte({8'h0A, 1'b0});
		send_byte({8'h61, 1'b0});
		send_byte({8'h5F, 1'b1});

		wait_drained();
		repeat (8) @(negedge clk);
		$display("Drove %0d text bytes in %0d random texts, closing with an unbroken run.",
			bytes_sent, text_count);
		$display("Compared %0d characters, %0d of them decode errors.",
			checked_count, error_result_count);
		if (mismatch_count == 0 && waiting_count == 0)
			$display("[utf8_decode_classify] OK");
		else
			$display("[utf8_decode_classify] ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/utf8dc_pkg.sv
rtl/core/utf8dc_classify.sv
rtl/core/utf8dc_decode.sv
rtl/core/utf8dc_out_reg.sv
rtl/core/utf8_decode_classify.sv
tb/utf8_decode_classify_checker.sv
tb/tb_utf8_decode_classify.sv
